[sv/u16u8_pkg.sv]
package u16u8_pkg;

    // job queue between front and back
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    typedef logic [20:0] code_point_t;

    // one job: optional replacement character first, then an optional code point
    typedef struct packed {
        logic        pre_fffd;
        logic        has_cp;
        code_point_t cp;
    } job_t;

    localparam code_point_t CpReplacement = 21'h00FFFD;
    localparam code_point_t CpPlaneOne    = 21'h010000;

    // number of utf-8 bytes minus one
    function automatic logic [1:0] utf8_len_m1(code_point_t cp);
        logic [1:0] len_m1;
        if (cp < 21'h000080) begin
            len_m1 = 2'd0;
        end else if (cp < 21'h000800) begin
            len_m1 = 2'd1;
        end else if (cp < 21'h010000) begin
            len_m1 = 2'd2;
        end else begin
            len_m1 = 2'd3;
        end
        return len_m1;
    endfunction

    // byte idx of the encoding of cp
    function automatic logic [7:0] utf8_byte(code_point_t cp, logic [1:0] len_m1,
                                             logic [1:0] idx);
        logic [7:0] b;
        case ({len_m1, idx})
            4'b00_00: b = {1'b0, cp[6:0]};
            4'b01_00: b = {3'b110, cp[10:6]};
            4'b01_01: b = {2'b10, cp[5:0]};
            4'b10_00: b = {4'b1110, cp[15:12]};
            4'b10_01: b = {2'b10, cp[11:6]};
            4'b10_10: b = {2'b10, cp[5:0]};
            4'b11_00: b = {5'b11110, cp[20:18]};
            4'b11_01: b = {2'b10, cp[17:12]};
            4'b11_10: b = {2'b10, cp[11:6]};
            4'b11_11: b = {2'b10, cp[5:0]};
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[sv/u16u8_front.sv]
module u16u8_front import u16u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic       big_endian_reg, big_endian_next;
    logic       lead_pending_reg, lead_pending_next;
    logic [9:0] lead_low_reg, lead_low_next;

    logic [15:0] unit;
    logic        is_lead, is_trail, accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~q_full;
    assign accept    = s_tvalid & s_tready;

    assign unit     = big_endian_reg ? s_tdata : {s_tdata[7:0], s_tdata[15:8]};
    assign is_lead  = (unit[15:10] == 6'b110110);
    assign is_trail = (unit[15:10] == 6'b110111);

    always_comb begin
        big_endian_next   = (cfg_valid & cfg_ready) ? cfg_data : big_endian_reg;
        lead_pending_next = lead_pending_reg;
        lead_low_next     = lead_low_reg;
        q_job.pre_fffd    = lead_pending_reg;
        q_job.has_cp      = 1'b0;
        q_job.cp          = CpReplacement;
        if (s_tlast) begin
            lead_pending_next = 1'b0;
        end else if (lead_pending_reg && is_trail) begin
            q_job.pre_fffd    = 1'b0;
            q_job.has_cp      = 1'b1;
            q_job.cp          = CpPlaneOne + {1'b0, lead_low_reg, unit[9:0]};
            lead_pending_next = 1'b0;
        end else if (is_lead) begin
            lead_pending_next = 1'b1;
            lead_low_next     = unit[9:0];
        end else begin
            lead_pending_next = 1'b0;
            q_job.has_cp      = 1'b1;
            q_job.cp          = is_trail ? CpReplacement : {5'd0, unit};
        end
        q_push = accept & (q_job.pre_fffd | q_job.has_cp);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg   <= 1'b0;
            lead_pending_reg <= 1'b0;
            lead_low_reg     <= '0;
        end else begin
            big_endian_reg <= big_endian_next;
            if (accept) begin
                lead_pending_reg <= lead_pending_next;
                lead_low_reg     <= lead_low_next;
            end
        end
    end

endmodule

[sv/u16u8_fifo.sv]
module u16u8_fifo import u16u8_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    job_t             entry_reg [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign full       = (count_reg == QCntW'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCntW'(push) - QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("push into full job queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid) else $error("pop from empty job queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCntW'(QueueDepth)) else $error("job queue count out of range");

endmodule

[sv/u16u8_back.sv]
module u16u8_back import u16u8_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  job_t       head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic        sel_fffd, seg_end, last, load;
    code_point_t cur_cp;
    logic [1:0]  len_m1;

    assign sel_fffd = head.pre_fffd & ~phase_reg;
    assign cur_cp   = sel_fffd ? CpReplacement : head.cp;
    assign len_m1   = utf8_len_m1(cur_cp);
    assign seg_end  = (idx_reg == len_m1);
    assign last     = seg_end & ~(sel_fffd & head.has_cp);
    assign load     = head_valid & (~m_tvalid_reg | m_tready);
    assign pop      = load & last;

    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            if (last) begin
                phase_next = 1'b0;
                idx_next   = '0;
            end else if (seg_end) begin
                phase_next = 1'b1;
                idx_next   = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= utf8_byte(cur_cp, len_m1, idx_reg);
            m_tlast_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_idx_in_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg <= len_m1) else $error("byte index past sequence end");
    a_phase_only_with_pre: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> head_valid && head.pre_fffd && head.has_cp)
        else $error("second segment without a replacement prefix");
    a_idle_at_job_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> idx_reg == 2'd0 && !phase_reg) else $error("sequencer not rewound");

endmodule

[sv/utf16_to_utf8_transcoder_top.sv]
// utf-16 to utf-8 transcoder: one 16-bit code unit in per transfer, utf-8 bytes out
// the first output byte of an item passes through the job queue and then the output register
// throughput: one output byte per cycle while m_tready allows; an item yields
//   1 to 3 bytes for a bmp unit, 4 for a surrogate pair, up to 6 with a replacement prefix;
//   the byte-wide output register sets this, a 4-entry job queue absorbs bursts
// reset (aresetn, synchronous, active low): little-endian order, no pending lead, queue empty
module utf16_to_utf8_transcoder_top import u16u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: big_endian
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,       // [0] big_endian
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [15:0] raw_unit
    input  logic        s_tlast,        // end_of_stream
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // [7:0] utf8_byte
    output logic        m_tlast         // last_of_run
);

    // front to queue
    logic q_push;
    job_t q_job;
    logic q_full;

    // queue to back
    logic head_valid;
    job_t head;
    logic pop;

    // front: byte order, surrogate pairing, one job per transfer that yields bytes
    u16u8_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // short job queue decoupling input acceptance from byte emission
    u16u8_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: walks each job one utf-8 byte per cycle, while m_tready allows, into the output register
    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[dv/tb_utf16_to_utf8_transcoder_top.sv]
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder_top;
    import u16u8_pkg::code_point_t;
    import u16u8_pkg::CpReplacement;
    import u16u8_pkg::CpPlaneOne;

    // surrogate ranges on the whole 16-bit unit
    localparam logic [15:0] LeadFirst  = 16'hD800;
    localparam logic [15:0] LeadLast   = 16'hDBFF;
    localparam logic [15:0] TrailFirst = 16'hDC00;
    localparam logic [15:0] TrailLast  = 16'hDFFF;

    localparam int ClkHalfNs     = 5;
    localparam int ResetCycles   = 10;
    localparam int SettleCycles  = 8;       // settle time after the last expected byte is out
    localparam int HoldOffCycles = 200;     // long receiver stall, fills the job queue
    localparam int RandomPhases  = 4;
    localparam int PhaseItems    = 75;
    localparam int MaxReported   = 10;
    localparam int TimeoutNs     = 2_000_000;

    // one byte on the output stream
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_beat_t;

    // one row of the directed table; bytes listed first byte in the top bits
    typedef struct packed {
        logic        be;
        logic [15:0] raw;
        logic        eos;
        logic        typed;
        logic [2:0]  n;
        logic [47:0] bytes;
    } directed_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'h0000;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // predicted transcoder state and register copy
    logic        exp_big_endian = 1'b0;
    logic        lead_held      = 1'b0;
    logic [9:0]  lead_bits      = 10'd0;

    // bytes of the item being predicted
    logic [7:0]  run_bytes [6];
    int          run_len;

    utf8_beat_t    expected_bytes[$];
    directed_row_t directed_rows[$];

    int errors = 0;

    // idling controls for the sender and the receiver
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_request   = 1'b0;

    utf16_to_utf8_transcoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #(ClkHalfNs) aclk = ~aclk;
    end

    // generous run limit
    initial begin
        #(TimeoutNs);
        $display("tb_utf16_to_utf8_transcoder_top: errors");
        $finish;
    end

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MaxReported) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        run_bytes[run_len] = b;
        run_len++;
    endtask

    // utf-8 encoding of one code point, out-of-range values become the replacement
    task automatic add_code_point(input code_point_t cp);
        if (cp >= 21'h110000) begin
            cp = CpReplacement;
        end
        if (cp < 21'h000080) begin
            add_byte({1'b0, cp[6:0]});
        end else if (cp < 21'h000800) begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h010000) begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end else begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endtask

    // next state and output bytes for one accepted input transfer
    task automatic predict_utf8(input logic [15:0] raw, input logic eos);
        logic [15:0] unit;
        run_len = 0;
        if (eos) begin
            // end of stream flushes a waiting lead
            if (lead_held) begin
                add_code_point(CpReplacement);
                lead_held = 1'b0;
                lead_bits = 10'd0;
            end
        end else begin
            unit = exp_big_endian ? raw : {raw[7:0], raw[15:8]};
            if (lead_held && unit >= TrailFirst && unit <= TrailLast) begin
                add_code_point(CpPlaneOne + {1'b0, lead_bits, unit[9:0]});
                lead_held = 1'b0;
                lead_bits = 10'd0;
            end else begin
                // lead without a trail is replaced before the new unit
                if (lead_held) begin
                    add_code_point(CpReplacement);
                    lead_held = 1'b0;
                    lead_bits = 10'd0;
                end
                if (unit >= LeadFirst && unit <= LeadLast) begin
                    lead_held = 1'b1;
                    lead_bits = unit[9:0];
                end else if (unit >= TrailFirst && unit <= TrailLast) begin
                    add_code_point(CpReplacement);
                end else begin
                    add_code_point({5'd0, unit});
                end
            end
        end
    endtask

    // stream byte order for a unit under the current setting
    function automatic logic [15:0] stream_bytes(input logic [15:0] unit);
        return exp_big_endian ? unit : {unit[7:0], unit[15:8]};
    endfunction

    // one input transfer; called at a rising edge, returns at the accepting edge
    task automatic send_unit(input logic [15:0] raw, input logic eos, input logic typed,
                             input logic [2:0] n_typed, input logic [47:0] bytes_typed);
        int gap;
        logic rdy;
        utf8_beat_t beat;
        gap = sender_idles ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tlast  <= eos;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            if (rdy) begin
                // transfer is certain now, so expectations land before the edge
                predict_utf8(raw, eos);
                if (typed) begin
                    for (int i = 0; i < n_typed; i++) begin
                        beat.data = bytes_typed[47 - 8 * i -: 8];
                        beat.last = (i == n_typed - 1);
                        expected_bytes.push_back(beat);
                    end
                end else begin
                    for (int i = 0; i < run_len; i++) begin
                        beat.data = run_bytes[i];
                        beat.last = (i == run_len - 1);
                        expected_bytes.push_back(beat);
                    end
                end
            end
            @(posedge aclk);
        end while (!rdy);
    endtask

    // stop offering, wait until every expected byte is out, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // register write; called at a rising edge with the block idle
    task automatic write_byte_order(input logic be);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_data  <= be;
        do begin
            @(negedge aclk);
            rdy = cfg_ready;
            if (rdy) begin
                exp_big_endian = be;
            end
            @(posedge aclk);
        end while (!rdy);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic be, input logic [15:0] raw, input logic eos,
                           input logic typed, input logic [2:0] n, input logic [47:0] bytes);
        directed_row_t row;
        row.be    = be;
        row.raw   = raw;
        row.eos   = eos;
        row.typed = typed;
        row.n     = n;
        row.bytes = bytes;
        directed_rows.push_back(row);
    endtask

    // mostly well-formed utf-16 with random content, some noise
    task automatic send_random(input int count);
        int sent;
        int kind;
        logic [15:0] u;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                case ($urandom_range(0, 2))
                    0: u = 16'($urandom_range(16'h0000, 16'h007F));
                    1: u = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: begin
                        u = 16'($urandom_range(16'h0800, 16'hFFFF));
                        if (u >= LeadFirst && u <= TrailLast) begin
                            u = u - 16'h1000;
                        end
                    end
                endcase
                send_unit(stream_bytes(u), 1'b0, 1'b0, 3'd0, 48'd0);
                sent++;
            end else if (kind < 65) begin
                // surrogate pair
                u = LeadFirst | 16'($urandom_range(0, 1023));
                send_unit(stream_bytes(u), 1'b0, 1'b0, 3'd0, 48'd0);
                u = TrailFirst | 16'($urandom_range(0, 1023));
                send_unit(stream_bytes(u), 1'b0, 1'b0, 3'd0, 48'd0);
                sent += 2;
            end else if (kind < 75) begin
                // lone lead, whatever follows decides its fate
                u = LeadFirst | 16'($urandom_range(0, 1023));
                send_unit(stream_bytes(u), 1'b0, 1'b0, 3'd0, 48'd0);
                sent++;
            end else if (kind < 83) begin
                u = TrailFirst | 16'($urandom_range(0, 1023));
                send_unit(stream_bytes(u), 1'b0, 1'b0, 3'd0, 48'd0);
                sent++;
            end else if (kind < 90) begin
                // end of stream, payload ignored
                send_unit(16'($urandom_range(0, 65535)), 1'b1, 1'b0, 3'd0, 48'd0);
                sent++;
            end else begin
                send_unit(16'($urandom_range(0, 65535)), 1'b0, 1'b0, 3'd0, 48'd0);
                sent++;
            end
        end
    endtask

    // receiver: random stall per byte, one long hold-off on request
    initial begin : result_receiver
        int stall;
        logic got;
        @(posedge aclk);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 7) : 0;
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HoldOffCycles;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid && aresetn;
                @(posedge aclk);
            end while (!got);
        end
    end

    // output checker: every transfer against the oldest expected byte
    initial begin : result_checker
        logic mv;
        logic mr;
        logic rst_n;
        logic [7:0] md;
        logic ml;
        utf8_beat_t want;
        forever begin
            @(negedge aclk);
            mv    = m_tvalid;
            mr    = m_tready;
            md    = m_tdata;
            ml    = m_tlast;
            rst_n = aresetn;
            @(posedge aclk);
            if (rst_n && mv && mr) begin
                if (expected_bytes.size() == 0) begin
                    note_error($sformatf("unexpected byte %02h last %b", md, ml));
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.data !== md) begin
                        note_error($sformatf("byte: expected %02h got %02h", want.data, md));
                    end
                    if (want.last !== ml) begin
                        note_error($sformatf("last on %02h: expected %b got %b",
                                             want.data, want.last, ml));
                    end
                end
            end
        end
    end

    // stimulus: directed table, then random phases under different settings
    initial begin : stimulus
        directed_row_t row;

        // directed table, byte order column switches the register when it changes
        //      be    raw       eos   typed  n     bytes
        add_row(1'b0, 16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00); // u+0000
        add_row(1'b0, 16'h7F00, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00); // top ascii
        add_row(1'b0, 16'h8000, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00); // first 2-byte
        add_row(1'b0, 16'hFF07, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00); // last 2-byte
        add_row(1'b0, 16'h0008, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00); // first 3-byte
        add_row(1'b0, 16'hFFFF, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00); // u+ffff
        add_row(1'b0, 16'h0000, 1'b1, 1'b1, 3'd0, 48'h00_00_00_00_00_00); // eos, idle
        add_row(1'b0, 16'h00DC, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00); // stray trail
        add_row(1'b0, 16'h00D8, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00); // lead held
        add_row(1'b0, 16'h00DC, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00); // u+10000
        add_row(1'b0, 16'hFFDB, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00); // top lead
        add_row(1'b0, 16'hFFDF, 1'b0, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00); // u+10ffff
        add_row(1'b0, 16'h00D8, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00);
        add_row(1'b0, 16'hFFDB, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00); // lead on lead
        add_row(1'b0, 16'h4100, 1'b0, 1'b1, 3'd4, 48'hEF_BF_BD_41_00_00); // lead, then ascii
        add_row(1'b0, 16'h34D8, 1'b0, 1'b0, 3'd0, 48'd0);
        add_row(1'b0, 16'h0030, 1'b0, 1'b0, 3'd0, 48'd0);                 // six bytes
        add_row(1'b0, 16'h12D9, 1'b0, 1'b0, 3'd0, 48'd0);
        add_row(1'b0, 16'h0000, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00); // eos flush
        add_row(1'b0, 16'hFFFF, 1'b1, 1'b1, 3'd0, 48'h00_00_00_00_00_00); // eos ignores data
        add_row(1'b1, 16'hD83D, 1'b0, 1'b0, 3'd0, 48'd0);
        add_row(1'b1, 16'hDE00, 1'b0, 1'b0, 3'd0, 48'd0);
        add_row(1'b1, 16'h00E9, 1'b0, 1'b0, 3'd0, 48'd0);
        add_row(1'b1, 16'h20AC, 1'b0, 1'b0, 3'd0, 48'd0);
        add_row(1'b1, 16'hD800, 1'b0, 1'b0, 3'd0, 48'd0);
        add_row(1'b1, 16'hDC00, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00); // eos, not a trail
        add_row(1'b1, 16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00);
        add_row(1'b1, 16'hFFFF, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00);

        // single reset pulse at the start of the run
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // write the reset value once before anything else
        write_byte_order(1'b0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.be != exp_big_endian) begin
                wait_drained();
                write_byte_order(row.be);
            end
            send_unit(row.raw, row.eos, row.typed, row.n, row.bytes);
        end

        for (int ph = 0; ph < RandomPhases; ph++) begin
            wait_drained();
            write_byte_order(ph[0] ? 1'b0 : 1'b1);
            case (ph)
                0: begin
                    // both sides idle, with a full drain halfway
                    sender_idles   = 1'b1;
                    receiver_idles = 1'b1;
                    send_random(PhaseItems / 2);
                    wait_drained();
                    send_random(PhaseItems - PhaseItems / 2);
                end
                1: begin
                    // back to back on both sides
                    sender_idles   = 1'b0;
                    receiver_idles = 1'b0;
                    send_random(PhaseItems);
                end
                2: begin
                    // receiver holds off while the sender keeps offering
                    sender_idles   = 1'b0;
                    receiver_idles = 1'b1;
                    hold_request   = 1'b1;
                    send_random(PhaseItems);
                end
                default: begin
                    sender_idles   = 1'b1;
                    receiver_idles = 1'b0;
                    send_random(PhaseItems);
                end
            endcase
        end

        wait_drained();

        // leftover expectations count as failures
        if (expected_bytes.size() != 0) begin
            note_error($sformatf("%0d expected bytes never came", expected_bytes.size()));
        end

        if (errors == 0) begin
            $display("tb_utf16_to_utf8_transcoder_top: clean");
        end else begin
            $display("tb_utf16_to_utf8_transcoder_top: errors");
        end
        $finish;
    end

endmodule
